@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL, included by iir_sos_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define IIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define IIR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/iir_sos_pkg.sv @@
// Types and constants shared by the IIR filter modules.
package iir_sos_pkg;

  localparam int unsigned MAX_TAPS_DEF     = 32;
  localparam int unsigned MAX_SECTIONS_DEF = 8;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = COEF_W + DATA_W;
  localparam int unsigned ACC_W      = 56;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned NSEC_W     = 4;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_FF_LEN  = 2'd1,
    CFG_FB_LEN  = 2'd2,
    CFG_NUM_SEC = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_FB,
    ST_FBW,
    ST_SH,
    ST_SHW,
    ST_OUT
  } state_e;

  // Tag that travels with each memory access through the MAC pipeline.
  typedef struct packed {
    logic vld;
    logic acc;
    logic neg;
    logic use_w;
    logic wr;
  } tag_t;

  typedef struct packed {
    logic load;
    logic clear;
  } mac_ctl_t;

endpackage

@@ hw/rtl/iir_sos_mem.sv @@
// Delay line and coefficient memories with per-entry valid bits.
module iir_sos_mem #(
  parameter int unsigned MaxTaps = iir_sos_pkg::MAX_TAPS_DEF,
  parameter int unsigned AddrW   = $clog2(MaxTaps)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [AddrW-1:0]                         dl_raddr_i,
  input  logic                                     dl_we_i,
  input  logic [AddrW-1:0]                         dl_waddr_i,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    dl_wdata_i,
  input  logic                                     dl_clr_i,
  output logic signed [iir_sos_pkg::DATA_W-1:0]    dl_rdata_o,
  input  logic [AddrW-1:0]                         coef_raddr_i,
  input  logic                                     ff_we_i,
  input  logic                                     fb_we_i,
  input  logic [AddrW-1:0]                         coef_waddr_i,
  input  logic signed [iir_sos_pkg::COEF_W-1:0]    coef_wdata_i,
  output logic signed [iir_sos_pkg::COEF_W-1:0]    ff_rdata_o,
  output logic signed [iir_sos_pkg::COEF_W-1:0]    fb_rdata_o
);

  logic signed [iir_sos_pkg::DATA_W-1:0] dl_mem [MaxTaps];
  logic signed [iir_sos_pkg::COEF_W-1:0] ff_mem [MaxTaps];
  logic signed [iir_sos_pkg::COEF_W-1:0] fb_mem [MaxTaps];

  logic [MaxTaps-1:0] dl_vld_q, ff_vld_q, fb_vld_q;
  logic signed [iir_sos_pkg::DATA_W-1:0] dl_rd_q;
  logic signed [iir_sos_pkg::COEF_W-1:0] ff_rd_q, fb_rd_q;
  logic dl_rv_q, ff_rv_q, fb_rv_q;

  always_ff @(posedge clk_i) begin
    if (dl_we_i) begin
      dl_mem[dl_waddr_i] <= dl_wdata_i;
    end
    if (ff_we_i) begin
      ff_mem[coef_waddr_i] <= coef_wdata_i;
    end
    if (fb_we_i) begin
      fb_mem[coef_waddr_i] <= coef_wdata_i;
    end
    dl_rd_q <= dl_mem[dl_raddr_i];
    ff_rd_q <= ff_mem[coef_raddr_i];
    fb_rd_q <= fb_mem[coef_raddr_i];
    dl_rv_q <= dl_vld_q[dl_raddr_i];
    ff_rv_q <= ff_vld_q[coef_raddr_i];
    fb_rv_q <= fb_vld_q[coef_raddr_i];
  end

  // An entry that has not been written since reset (or since a clear, for
  // the delay line) reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
      ff_vld_q <= '0;
      fb_vld_q <= '0;
    end else begin
      if (dl_clr_i) begin
        dl_vld_q <= '0;
      end else if (dl_we_i) begin
        dl_vld_q[dl_waddr_i] <= 1'b1;
      end
      if (ff_we_i) begin
        ff_vld_q[coef_waddr_i] <= 1'b1;
      end
      if (fb_we_i) begin
        fb_vld_q[coef_waddr_i] <= 1'b1;
      end
    end
  end

  assign dl_rdata_o = dl_rv_q ? dl_rd_q : '0;
  assign ff_rdata_o = ff_rv_q ? ff_rd_q : '0;
  assign fb_rdata_o = fb_rv_q ? fb_rd_q : '0;

endmodule

@@ hw/rtl/iir_sos_mac.sv @@
// Shared multiply-accumulate with rounding and saturation of the accumulator.
module iir_sos_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  iir_sos_pkg::mac_ctl_t                    ctl_i,
  input  iir_sos_pkg::tag_t                        tag_i,
  input  logic signed [iir_sos_pkg::COEF_W-1:0]    ff_coef_i,
  input  logic signed [iir_sos_pkg::COEF_W-1:0]    fb_coef_i,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    dl_data_i,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    w_i,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    t_i,
  output logic                                     busy_o,
  output logic signed [iir_sos_pkg::DATA_W-1:0]    w_o,
  output logic signed [iir_sos_pkg::SAMPLE_W-1:0]  y_o,
  output logic                                     y_sat_o
);

  localparam int unsigned AccW  = iir_sos_pkg::ACC_W;
  localparam int unsigned ProdW = iir_sos_pkg::PROD_W;
  localparam int unsigned DataW = iir_sos_pkg::DATA_W;

  logic signed [iir_sos_pkg::COEF_W-1:0] coef;
  logic signed [DataW-1:0]               data;
  logic signed [ProdW-1:0]               prod_q;
  logic                                  vld2_q, acc2_q, neg2_q;
  logic signed [AccW-1:0]                acc_q, acc_d;
  logic signed [AccW-1:0]                rnd15, rnd23;

  assign coef = tag_i.neg ? fb_coef_i : ff_coef_i;
  assign data = tag_i.use_w ? w_i : dl_data_i;

  always_ff @(posedge clk_i) begin
    prod_q <= coef * data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      acc2_q <= 1'b0;
      neg2_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      vld2_q <= tag_i.vld;
      acc2_q <= tag_i.acc;
      neg2_q <= tag_i.neg;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = AccW'(t_i) <<< 15;
    end else if (ctl_i.clear) begin
      acc_d = '0;
    end else if (vld2_q && acc2_q) begin
      if (neg2_q) begin
        acc_d = acc_q - AccW'(prod_q);
      end else begin
        acc_d = acc_q + AccW'(prod_q);
      end
    end
  end

  assign busy_o = vld2_q;

  // Round half up from the Q.23 accumulator to the Q.8 word and the Q.0 sample, then saturate.
  assign rnd15 = (acc_q + AccW'(64'sd1 <<< 14)) >>> 15;
  assign rnd23 = (acc_q + AccW'(64'sd1 <<< 22)) >>> 23;

  always_comb begin
    if (rnd15 > AccW'(64'sd2147483647)) begin
      w_o = 32'sh7fffffff;
    end else if (rnd15 < -AccW'(64'sd2147483648)) begin
      w_o = 32'sh80000000;
    end else begin
      w_o = DataW'(rnd15);
    end
    y_sat_o = 1'b1;
    if (rnd23 > AccW'(64'sd32767)) begin
      y_o = 16'sh7fff;
    end else if (rnd23 < -AccW'(64'sd32768)) begin
      y_o = 16'sh8000;
    end else begin
      y_o     = iir_sos_pkg::SAMPLE_W'(rnd23);
      y_sat_o = 1'b0;
    end
  end

endmodule

@@ hw/rtl/iir_sos_ctrl.sv @@
// Sequencer: configuration, coefficient writes and clears, tap addressing, delay write-back and output word.
`include "assert_macros.svh"

module iir_sos_ctrl #(
  parameter int unsigned MaxTaps     = iir_sos_pkg::MAX_TAPS_DEF,
  parameter int unsigned MaxSections = iir_sos_pkg::MAX_SECTIONS_DEF,
  parameter int unsigned AddrW       = $clog2(MaxTaps)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [iir_sos_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [iir_sos_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [iir_sos_pkg::CMD_W-1:0]            command_i,
  input  logic                                     coef_select_i,
  input  logic [iir_sos_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [iir_sos_pkg::COEF_W-1:0]    coef_value_i,
  input  logic signed [iir_sos_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [iir_sos_pkg::SAMPLE_W-1:0]  filtered_sample_o,
  output logic                                     saturated_o,
  output logic [AddrW-1:0]                         dl_raddr_o,
  output logic                                     dl_we_o,
  output logic [AddrW-1:0]                         dl_waddr_o,
  output logic signed [iir_sos_pkg::DATA_W-1:0]    dl_wdata_o,
  output logic                                     dl_clr_o,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    dl_rdata_i,
  output logic [AddrW-1:0]                         coef_raddr_o,
  output logic                                     ff_we_o,
  output logic                                     fb_we_o,
  output logic [AddrW-1:0]                         coef_waddr_o,
  output logic signed [iir_sos_pkg::COEF_W-1:0]    coef_wdata_o,
  output iir_sos_pkg::tag_t                        tag_o,
  output iir_sos_pkg::mac_ctl_t                    mac_ctl_o,
  output logic signed [iir_sos_pkg::DATA_W-1:0]    w_o,
  output logic signed [iir_sos_pkg::DATA_W-1:0]    t_o,
  input  logic                                     mac_busy_i,
  input  logic signed [iir_sos_pkg::DATA_W-1:0]    mac_w_i,
  input  logic signed [iir_sos_pkg::SAMPLE_W-1:0]  mac_y_i,
  input  logic                                     mac_y_sat_i
);

  localparam int unsigned CntW   = $clog2(MaxTaps + 1);
  localparam int unsigned SecLim = (MaxSections < MaxTaps / 3) ? MaxSections : MaxTaps / 3;
  localparam int unsigned SecW   = (SecLim > 1) ? $clog2(SecLim) : 1;
  localparam int unsigned DataW  = iir_sos_pkg::DATA_W;

  iir_sos_pkg::state_e state_q, state_d;

  logic                               mode_q;
  logic [iir_sos_pkg::LEN_W-1:0]      ff_len_q, fb_len_q;
  logic [iir_sos_pkg::NSEC_W-1:0]     nsec_q;

  logic [AddrW-1:0]        i_q, i_d, base_q, base_d, waddr1_q;
  logic [SecW-1:0]         sect_q, sect_d, sect_last;
  logic signed [DataW-1:0] w_q, w_d, t_q, t_d;
  iir_sos_pkg::tag_t       iss, tag1_q;
  logic [AddrW-1:0]        iss_waddr;

  logic                                    out_vld_q, out_vld_d, out_sat_q, out_load;
  logic signed [iir_sos_pkg::SAMPLE_W-1:0] out_y_q;

  logic [CntW-1:0] nf_clamp, nr_clamp, nf, nr, n;
  logic            accept;
  logic            pipe_empty;

  // Effective lengths; a cascade section always uses three taps.
  always_comb begin
    if (ff_len_q == '0) begin
      nf_clamp = CntW'(1);
    end else if (int'(ff_len_q) > MaxTaps) begin
      nf_clamp = CntW'(MaxTaps);
    end else begin
      nf_clamp = CntW'(ff_len_q);
    end
    if (fb_len_q == '0) begin
      nr_clamp = CntW'(1);
    end else if (int'(fb_len_q) > MaxTaps) begin
      nr_clamp = CntW'(MaxTaps);
    end else begin
      nr_clamp = CntW'(fb_len_q);
    end
    if (nsec_q == '0) begin
      sect_last = '0;
    end else if (int'(nsec_q) > SecLim) begin
      sect_last = SecW'(SecLim - 1);
    end else begin
      sect_last = SecW'(nsec_q - iir_sos_pkg::NSEC_W'(1));
    end
    nf = mode_q ? CntW'(3) : nf_clamp;
    nr = mode_q ? CntW'(3) : nr_clamp;
    n  = (nf > nr) ? nf : nr;
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == iir_sos_pkg::ST_IDLE);
  assign pipe_empty = !tag1_q.vld && !mac_busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      ff_len_q <= iir_sos_pkg::LEN_W'(1);
      fb_len_q <= iir_sos_pkg::LEN_W'(1);
      nsec_q   <= iir_sos_pkg::NSEC_W'(1);
    end else if (cfg_we_i) begin
      case (iir_sos_pkg::cfg_idx_e'(cfg_idx_i))
        iir_sos_pkg::CFG_MODE:    mode_q   <= cfg_wdata_i[0];
        iir_sos_pkg::CFG_FF_LEN:  ff_len_q <= cfg_wdata_i;
        iir_sos_pkg::CFG_FB_LEN:  fb_len_q <= cfg_wdata_i;
        iir_sos_pkg::CFG_NUM_SEC: nsec_q   <= cfg_wdata_i[iir_sos_pkg::NSEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient writes and clears complete in the cycle they are accepted.
  assign coef_waddr_o = AddrW'(coef_index_i);
  assign coef_wdata_o = coef_value_i;
  always_comb begin
    ff_we_o  = 1'b0;
    fb_we_o  = 1'b0;
    dl_clr_o = 1'b0;
    if (accept) begin
      case (iir_sos_pkg::cmd_e'(command_i))
        iir_sos_pkg::CMD_WRITE: begin
          if (int'(coef_index_i) < MaxTaps) begin
            ff_we_o = !coef_select_i;
            fb_we_o = coef_select_i;
          end
        end
        iir_sos_pkg::CMD_CLEAR: dl_clr_o = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    base_d       = base_q;
    sect_d       = sect_q;
    w_d          = w_q;
    t_d          = t_q;
    iss          = '0;
    iss_waddr    = base_q + i_q;
    dl_raddr_o   = base_q + i_q - AddrW'(1);
    coef_raddr_o = base_q + i_q;
    mac_ctl_o    = '0;
    out_load     = 1'b0;
    case (state_q)
      iir_sos_pkg::ST_IDLE: begin
        if (accept && iir_sos_pkg::cmd_e'(command_i) == iir_sos_pkg::CMD_FILTER) begin
          t_d     = DataW'(sample_i) <<< 8;
          base_d  = '0;
          sect_d  = '0;
          state_d = iir_sos_pkg::ST_SEC;
        end
      end
      iir_sos_pkg::ST_SEC: begin
        mac_ctl_o.load = 1'b1;
        i_d            = AddrW'(1);
        state_d        = iir_sos_pkg::ST_FB;
      end
      // Feedback taps read the old word one place below, since the line
      // shifts after the new head word is formed. The last tap moves on
      // at once, as the index cannot count past the top of the line.
      iir_sos_pkg::ST_FB: begin
        if (CntW'(i_q) < nr) begin
          iss.vld = 1'b1;
          iss.acc = 1'b1;
          iss.neg = 1'b1;
          i_d     = i_q + AddrW'(1);
          if (CntW'(i_q) == nr - CntW'(1)) begin
            state_d = iir_sos_pkg::ST_FBW;
          end
        end else begin
          state_d = iir_sos_pkg::ST_FBW;
        end
      end
      iir_sos_pkg::ST_FBW: begin
        if (pipe_empty) begin
          w_d             = mac_w_i;
          mac_ctl_o.clear = 1'b1;
          i_d             = AddrW'(n - CntW'(1));
          state_d         = iir_sos_pkg::ST_SH;
        end
      end
      // Shift from the top down so that no word is overwritten before it
      // has been read; the head word goes in last.
      iir_sos_pkg::ST_SH: begin
        iss.vld = 1'b1;
        iss.wr  = 1'b1;
        if (i_q != '0) begin
          iss.acc = (CntW'(i_q) < nf);
          i_d     = i_q - AddrW'(1);
        end else begin
          iss.acc   = 1'b1;
          iss.use_w = 1'b1;
          state_d   = iir_sos_pkg::ST_SHW;
        end
      end
      iir_sos_pkg::ST_SHW: begin
        if (pipe_empty) begin
          if (mode_q && sect_q != sect_last) begin
            t_d     = mac_w_i;
            base_d  = base_q + AddrW'(3);
            sect_d  = sect_q + SecW'(1);
            state_d = iir_sos_pkg::ST_SEC;
          end else begin
            state_d = iir_sos_pkg::ST_OUT;
          end
        end
      end
      iir_sos_pkg::ST_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = iir_sos_pkg::ST_IDLE;
        end
      end
      default: state_d = iir_sos_pkg::ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= iir_sos_pkg::ST_IDLE;
      tag1_q    <= '0;
      out_vld_q <= 1'b0;
      i_q       <= '0;
      base_q    <= '0;
      sect_q    <= '0;
    end else begin
      state_q   <= state_d;
      tag1_q    <= iss;
      out_vld_q <= out_vld_d;
      i_q       <= i_d;
      base_q    <= base_d;
      sect_q    <= sect_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    t_q      <= t_d;
    waddr1_q <= iss_waddr;
    if (out_load) begin
      out_y_q   <= mac_y_i;
      out_sat_q <= mac_y_sat_i;
    end
  end

  assign dl_we_o    = tag1_q.vld && tag1_q.wr;
  assign dl_waddr_o = waddr1_q;
  assign dl_wdata_o = tag1_q.use_w ? w_q : dl_rdata_i;
  assign tag_o      = tag1_q;
  assign w_o        = w_q;
  assign t_o        = t_q;

  assign out_valid_o       = out_vld_q;
  assign filtered_sample_o = out_y_q;
  assign saturated_o       = out_sat_q;

  `IIR_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == iir_sos_pkg::ST_IDLE && !out_vld_q), "reset left the sequencer busy")
  `IIR_ASSERT(a_idle_no_write, (state_q == iir_sos_pkg::ST_IDLE) |-> !tag1_q.vld, "memory access in flight while idle")
  `IIR_ASSERT(a_shift_in_range, (state_q == iir_sos_pkg::ST_SH) |-> (CntW'(i_q) < n), "shift index beyond the delay line")
  `IIR_ASSERT(a_section_in_range, (state_q != iir_sos_pkg::ST_IDLE) |-> (sect_q <= sect_last), "section count overrun")

endmodule

@@ hw/rtl/iir_direct_form2_sos_filter_unit.sv @@
// Direct-form-II IIR filter, single or cascaded second-order sections.
// A coefficient write or a delay-line clear completes in the cycle it is
// accepted. A filter word runs through one shared multiply-accumulate fed by
// the one read port of the delay memory: the feedback taps first, then the
// shift of the line with the feedforward taps; in cascade mode this repeats
// for each section. The result sits in an output register, and the
// next word is taken while it waits. Reset and clear need no sweep: each memory
// entry carries a valid bit, and an entry not yet written reads as zero.
module iir_direct_form2_sos_filter_unit #(
  parameter int unsigned MaxTaps     = iir_sos_pkg::MAX_TAPS_DEF,
  parameter int unsigned MaxSections = iir_sos_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [iir_sos_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [iir_sos_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [iir_sos_pkg::CMD_W-1:0]            command_i,
  input  logic                                     coef_select_i,
  input  logic [iir_sos_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [iir_sos_pkg::COEF_W-1:0]    coef_value_i,
  input  logic signed [iir_sos_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [iir_sos_pkg::SAMPLE_W-1:0]  filtered_sample_o,
  output logic                                     saturated_o
);

  localparam int unsigned AddrW = $clog2(MaxTaps);

  logic [AddrW-1:0]                        dl_raddr, dl_waddr, coef_raddr, coef_waddr;
  logic                                    dl_we, dl_clr, ff_we, fb_we, mac_busy, mac_y_sat;
  logic signed [iir_sos_pkg::DATA_W-1:0]   dl_wdata, dl_rdata, w, t, mac_w;
  logic signed [iir_sos_pkg::COEF_W-1:0]   coef_wdata, ff_rdata, fb_rdata;
  logic signed [iir_sos_pkg::SAMPLE_W-1:0] mac_y;
  iir_sos_pkg::tag_t                       tag;
  iir_sos_pkg::mac_ctl_t                   mac_ctl;

  iir_sos_mem #(
    .MaxTaps (MaxTaps),
    .AddrW   (AddrW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dl_raddr_i   (dl_raddr),
    .dl_we_i      (dl_we),
    .dl_waddr_i   (dl_waddr),
    .dl_wdata_i   (dl_wdata),
    .dl_clr_i     (dl_clr),
    .dl_rdata_o   (dl_rdata),
    .coef_raddr_i (coef_raddr),
    .ff_we_i      (ff_we),
    .fb_we_i      (fb_we),
    .coef_waddr_i (coef_waddr),
    .coef_wdata_i (coef_wdata),
    .ff_rdata_o   (ff_rdata),
    .fb_rdata_o   (fb_rdata)
  );

  iir_sos_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .tag_i     (tag),
    .ff_coef_i (ff_rdata),
    .fb_coef_i (fb_rdata),
    .dl_data_i (dl_rdata),
    .w_i       (w),
    .t_i       (t),
    .busy_o    (mac_busy),
    .w_o       (mac_w),
    .y_o       (mac_y),
    .y_sat_o   (mac_y_sat)
  );

  iir_sos_ctrl #(
    .MaxTaps     (MaxTaps),
    .MaxSections (MaxSections),
    .AddrW       (AddrW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .coef_select_i     (coef_select_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .filtered_sample_o (filtered_sample_o),
    .saturated_o       (saturated_o),
    .dl_raddr_o        (dl_raddr),
    .dl_we_o           (dl_we),
    .dl_waddr_o        (dl_waddr),
    .dl_wdata_o        (dl_wdata),
    .dl_clr_o          (dl_clr),
    .dl_rdata_i        (dl_rdata),
    .coef_raddr_o      (coef_raddr),
    .ff_we_o           (ff_we),
    .fb_we_o           (fb_we),
    .coef_waddr_o      (coef_waddr),
    .coef_wdata_o      (coef_wdata),
    .tag_o             (tag),
    .mac_ctl_o         (mac_ctl),
    .w_o               (w),
    .t_o               (t),
    .mac_busy_i        (mac_busy),
    .mac_w_i           (mac_w),
    .mac_y_i           (mac_y),
    .mac_y_sat_i       (mac_y_sat)
  );

endmodule
